### src/isu_pkg.sv
// Package for the interval set block: field widths, command, status and
// cell operation codes, and the cell control struct. No dependencies.
package isu_pkg;

  localparam int DEF_MAX_INTERVALS = 16;
  localparam int DEF_COORD_BITS    = 32;
  localparam int FIELD_W           = 32;
  localparam int TOTAL_W           = 36;

  localparam logic [1:0] CMD_ADD       = 2'd0;
  localparam logic [1:0] CMD_NORMALIZE = 2'd1;
  localparam logic [1:0] CMD_QUERY     = 2'd2;
  localparam logic [1:0] CMD_CLEAR     = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_BNDS = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NOT_NORM = 2'd3;

  localparam logic [2:0] CELL_HOLD  = 3'd0;
  localparam logic [2:0] CELL_WRITE = 3'd1;
  localparam logic [2:0] CELL_LOAD  = 3'd2;
  localparam logic [2:0] CELL_SORT  = 3'd3;
  localparam logic [2:0] CELL_SHIFT = 3'd4;

  typedef struct packed {
    logic [2:0] op;
    logic       phase;
  } cell_ctl_t;

endpackage

### src/isu_cell.sv
// One storage cell of the interval chain: holds one interval and a live bit.
// Depends on isu_pkg for the cell control struct and operation codes.
module isu_cell import isu_pkg::*; #(
  parameter int COORD_BITS    = DEF_COORD_BITS,
  parameter int MAX_INTERVALS = DEF_MAX_INTERVALS,
  parameter int INDEX         = 0,
  localparam int IDX_W = $clog2(MAX_INTERVALS),
  localparam int CNT_W = $clog2(MAX_INTERVALS + 1)
) (
  input  logic                  clk,
  input  cell_ctl_t             ctl,
  input  logic [IDX_W-1:0]      wr_idx,
  input  logic [COORD_BITS-1:0] wr_lo,
  input  logic [COORD_BITS-1:0] wr_hi,
  input  logic                  wr_live,
  input  logic [CNT_W-1:0]      count,
  input  logic [COORD_BITS-1:0] left_lo,
  input  logic [COORD_BITS-1:0] left_hi,
  input  logic                  left_live,
  input  logic [COORD_BITS-1:0] right_lo,
  input  logic [COORD_BITS-1:0] right_hi,
  input  logic                  right_live,
  output logic [COORD_BITS-1:0] lo,
  output logic [COORD_BITS-1:0] hi,
  output logic                  live
);

  localparam logic ODD = ((INDEX % 2) == 1);

  function automatic logic gt(input logic al, input logic [COORD_BITS-1:0] alo,
                              input logic [COORD_BITS-1:0] ahi, input logic bl,
                              input logic [COORD_BITS-1:0] blo,
                              input logic [COORD_BITS-1:0] bhi);
    gt = (!al && bl) || (al && bl && (alo > blo || (alo == blo && ahi > bhi)));
  endfunction

  logic pair_right, pair_left;

  assign pair_right = (ctl.phase == ODD) && (INDEX < MAX_INTERVALS - 1);
  assign pair_left  = (ctl.phase != ODD) && (INDEX > 0);

  always_ff @(posedge clk) begin
    case (ctl.op)
      CELL_WRITE: begin
        if (wr_idx == IDX_W'(INDEX)) begin
          lo   <= wr_lo;
          hi   <= wr_hi;
          live <= wr_live;
        end
      end
      CELL_LOAD: begin
        live <= (CNT_W'(INDEX) < count);
      end
      CELL_SORT: begin
        if (pair_right && gt(live, lo, hi, right_live, right_lo, right_hi)) begin
          lo   <= right_lo;
          hi   <= right_hi;
          live <= right_live;
        end else if (pair_left && gt(left_live, left_lo, left_hi, live, lo, hi)) begin
          lo   <= left_lo;
          hi   <= left_hi;
          live <= left_live;
        end
      end
      CELL_SHIFT: begin
        lo   <= right_lo;
        hi   <= right_hi;
        live <= right_live;
      end
      default: begin
      end
    endcase
  end

endmodule

### src/interval_set_union_and_rank_select.sv
// Top level of the interval set: command decode, sequencer and cell chain.
// Depends on isu_pkg and isu_cell.
//
// Add and clear give one result in the next cycle. A rank query is busy
// while it walks the chain, one stored interval passing the head each cycle,
// and gives a result for each one that overlaps the rank range, or one empty
// result if none does. Normalize is busy for an odd-even sort of the chain,
// a merge walk, a second sort that compacts, then one result per cycle.
// Results are shown for one cycle with valid high and cannot be held off.
module interval_set_union_and_rank_select import isu_pkg::*; #(
  parameter int MAX_INTERVALS = DEF_MAX_INTERVALS,
  parameter int COORD_BITS    = DEF_COORD_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         command,
  input  logic [FIELD_W-1:0] lower,
  input  logic [FIELD_W-1:0] upper,
  input  logic [TOTAL_W-1:0] rank_start,
  input  logic [TOTAL_W-1:0] rank_end,
  output logic               valid,
  output logic [1:0]         status,
  output logic [FIELD_W-1:0] lower_res,
  output logic [FIELD_W-1:0] upper_res,
  output logic [TOTAL_W-1:0] total_size,
  output logic               from_zero,
  output logic               is_empty,
  output logic               last
);

  localparam int N     = MAX_INTERVALS;
  localparam int IDX_W = $clog2(N);
  localparam int CNT_W = $clog2(N + 1);
  localparam int MAXW  = (COORD_BITS > TOTAL_W) ? COORD_BITS : TOTAL_W;
  localparam int CW    = MAXW + CNT_W + 1;
  localparam logic [MAXW:0] TOT_MAX = (MAXW + 1)'({TOTAL_W{1'b1}});

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SORT1 = 3'd1;
  localparam logic [2:0] S_MERGE = 3'd2;
  localparam logic [2:0] S_FLUSH = 3'd3;
  localparam logic [2:0] S_SORT2 = 3'd4;
  localparam logic [2:0] S_PREP  = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;
  localparam logic [2:0] S_QUERY = 3'd7;

  logic [2:0]            state;
  logic [CNT_W-1:0]      cnt;
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      m;
  logic                  normalized;
  logic [TOTAL_W-1:0]    covered;
  logic [TOTAL_W-1:0]    tot;
  logic                  fz;
  logic                  have;
  logic                  any_out;
  logic [COORD_BITS-1:0] acc_lo, acc_hi;
  logic [CW-1:0]         cur, r0, r1;

  logic [COORD_BITS-1:0] c_lo [N];
  logic [COORD_BITS-1:0] c_hi [N];
  logic                  c_live [N];

  cell_ctl_t             ctl;
  logic [IDX_W-1:0]      wr_idx;
  logic [COORD_BITS-1:0] wr_lo, wr_hi, tail_lo, tail_hi;
  logic                  wr_live, tail_live;

  logic [63:0]           lower_ext, upper_ext;
  logic [COORD_BITS-1:0] in_lo, in_hi;
  logic                  head_ok, merge_in, push;
  logic [MAXW:0]         add_sum;
  logic [TOTAL_W-1:0]    tot_add;
  logic [CW-1:0]         len, nxt, st, en, piece_lo, piece_hi;
  logic                  q_in, q_emit, q_last;
  logic [CNT_W:0]        cnt_inc;
  logic                  cnt_end;

  assign lower_ext = {32'd0, lower};
  assign upper_ext = {32'd0, upper};
  assign in_lo     = lower_ext[COORD_BITS-1:0];
  assign in_hi     = upper_ext[COORD_BITS-1:0];
  assign busy      = (state != S_IDLE);
  assign cnt_inc   = {1'b0, cnt} + 1'b1;
  assign cnt_end   = (cnt_inc == (CNT_W + 1)'(N));

  assign head_ok  = c_live[0] && (c_hi[0] > c_lo[0]);
  assign merge_in = have && (c_lo[0] <= acc_hi);
  assign push     = head_ok && have && !merge_in;
  assign add_sum  = (MAXW + 1)'(tot) + (MAXW + 1)'(acc_hi - acc_lo);
  assign tot_add  = (add_sum > TOT_MAX) ? TOT_MAX[TOTAL_W-1:0] : add_sum[TOTAL_W-1:0];

  assign len      = CW'(c_hi[0] - c_lo[0]);
  assign nxt      = cur + len;
  assign st       = (r0 > cur) ? r0 - cur : '0;
  assign en       = (r1 >= nxt) ? len : r1 - cur;
  assign q_in     = (cnt < count) && (r1 > cur) && (st < len) && (en > st);
  assign q_emit   = q_in;
  assign q_last   = !((r1 > nxt) && (cnt_inc < (CNT_W + 1)'(count)));
  assign piece_lo = CW'(c_lo[0]) + st;
  assign piece_hi = CW'(c_lo[0]) + en;

  always_comb begin
    ctl       = '{op: CELL_HOLD, phase: cnt[0]};
    wr_idx    = count[IDX_W-1:0];
    wr_lo     = in_lo;
    wr_hi     = in_hi;
    wr_live   = 1'b1;
    tail_lo   = c_lo[0];
    tail_hi   = c_hi[0];
    tail_live = c_live[0];
    case (state)
      S_IDLE: begin
        if (start && command == CMD_ADD && !(in_hi < in_lo) && CNT_W'(N) > count) begin
          ctl.op = CELL_WRITE;
        end else if (start && command == CMD_NORMALIZE) begin
          ctl.op = CELL_LOAD;
        end
      end
      S_SORT1, S_SORT2: ctl.op = CELL_SORT;
      S_MERGE: begin
        ctl.op    = CELL_SHIFT;
        tail_lo   = acc_lo;
        tail_hi   = acc_hi;
        tail_live = push;
      end
      S_FLUSH: begin
        ctl.op  = CELL_WRITE;
        wr_idx  = '0;
        wr_lo   = acc_lo;
        wr_hi   = acc_hi;
        wr_live = have;
      end
      S_EMIT, S_QUERY: ctl.op = CELL_SHIFT;
      default: ctl.op = CELL_HOLD;
    endcase
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic [COORD_BITS-1:0] l_lo, l_hi, r_lo, r_hi;
    logic                  l_live, r_live;
    if (i == 0) begin : g_first
      assign l_lo = tail_lo;
      assign l_hi = tail_hi;
      assign l_live = tail_live;
    end else begin : g_mid_l
      assign l_lo = c_lo[i-1];
      assign l_hi = c_hi[i-1];
      assign l_live = c_live[i-1];
    end
    if (i == N - 1) begin : g_last
      assign r_lo = tail_lo;
      assign r_hi = tail_hi;
      assign r_live = tail_live;
    end else begin : g_mid_r
      assign r_lo = c_lo[i+1];
      assign r_hi = c_hi[i+1];
      assign r_live = c_live[i+1];
    end
    isu_cell #(
      .COORD_BITS(COORD_BITS),
      .MAX_INTERVALS(N),
      .INDEX(i)
    ) u_cell (
      .clk(clk),
      .ctl(ctl),
      .wr_idx(wr_idx),
      .wr_lo(wr_lo),
      .wr_hi(wr_hi),
      .wr_live(wr_live),
      .count(count),
      .left_lo(l_lo),
      .left_hi(l_hi),
      .left_live(l_live),
      .right_lo(r_lo),
      .right_hi(r_hi),
      .right_live(r_live),
      .lo(c_lo[i]),
      .hi(c_hi[i]),
      .live(c_live[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cnt        <= '0;
      count      <= '0;
      normalized <= 1'b1;
      covered    <= '0;
      valid      <= 1'b0;
    end else begin
      valid      <= 1'b0;
      status     <= ST_OK;
      lower_res  <= '0;
      upper_res  <= '0;
      total_size <= '0;
      from_zero  <= 1'b0;
      is_empty   <= 1'b1;
      last       <= 1'b1;
      case (state)
        S_IDLE: begin
          cnt <= '0;
          if (start) begin
            case (command)
              CMD_ADD: begin
                valid <= 1'b1;
                if (in_hi < in_lo) begin
                  status <= ST_BAD_BNDS;
                end else if (!(CNT_W'(N) > count)) begin
                  status <= ST_FULL;
                end else begin
                  count      <= count + 1'b1;
                  normalized <= 1'b0;
                end
              end
              CMD_NORMALIZE: begin
                state <= S_SORT1;
              end
              CMD_QUERY: begin
                if (!normalized) begin
                  valid  <= 1'b1;
                  status <= ST_NOT_NORM;
                end else begin
                  state   <= S_QUERY;
                  cur     <= '0;
                  r0      <= CW'(rank_start);
                  r1      <= CW'(rank_end);
                  any_out <= 1'b0;
                  fz      <= (count == '0) || (count == CNT_W'(1) && c_lo[0] == '0);
                end
              end
              CMD_CLEAR: begin
                valid      <= 1'b1;
                from_zero  <= 1'b1;
                count      <= '0;
                normalized <= 1'b1;
                covered    <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        S_SORT1: begin
          cnt <= cnt + 1'b1;
          if (cnt_end) begin
            state <= S_MERGE;
            cnt   <= '0;
            have  <= 1'b0;
            m     <= '0;
            tot   <= '0;
          end
        end
        S_MERGE: begin
          cnt <= cnt + 1'b1;
          if (head_ok) begin
            if (merge_in) begin
              if (c_hi[0] > acc_hi) begin
                acc_hi <= c_hi[0];
              end
            end else begin
              acc_lo <= c_lo[0];
              acc_hi <= c_hi[0];
              have   <= 1'b1;
            end
          end
          if (push) begin
            m   <= m + 1'b1;
            tot <= tot_add;
          end
          if (cnt_end) begin
            state <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          if (have) begin
            m   <= m + 1'b1;
            tot <= tot_add;
          end
          cnt   <= '0;
          state <= S_SORT2;
        end
        S_SORT2: begin
          cnt <= cnt + 1'b1;
          if (cnt_end) begin
            state <= S_PREP;
          end
        end
        S_PREP: begin
          count      <= m;
          covered    <= tot;
          normalized <= 1'b1;
          fz         <= (m == '0) || (m == CNT_W'(1) && c_lo[0] == '0);
          cnt        <= '0;
          state      <= S_EMIT;
        end
        S_EMIT: begin
          cnt <= cnt + 1'b1;
          if (count == '0 && cnt == '0) begin
            valid      <= 1'b1;
            total_size <= covered;
            from_zero  <= fz;
          end else if (cnt < count) begin
            valid      <= 1'b1;
            lower_res  <= FIELD_W'(CW'(c_lo[0]));
            upper_res  <= FIELD_W'(CW'(c_hi[0]));
            total_size <= covered;
            from_zero  <= fz;
            is_empty   <= 1'b0;
            last       <= (cnt_inc == (CNT_W + 1)'(count));
          end
          if (cnt_end) begin
            state <= S_IDLE;
          end
        end
        S_QUERY: begin
          cnt <= cnt + 1'b1;
          cur <= nxt;
          if (q_emit) begin
            any_out    <= 1'b1;
            valid      <= 1'b1;
            lower_res  <= piece_lo[FIELD_W-1:0];
            upper_res  <= piece_hi[FIELD_W-1:0];
            total_size <= covered;
            from_zero  <= fz;
            is_empty   <= 1'b0;
            last       <= q_last;
          end else if (cnt_end && !any_out) begin
            valid      <= 1'b1;
            total_size <= covered;
            from_zero  <= fz;
          end
          if (cnt_end) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### verif/interval_set_union_and_rank_select_test.sv
// Testbench for the interval set block: directed and random requests with a
// scoreboard that predicts every result. Depends on isu_pkg and the block.
`timescale 1ns / 1ps

module interval_set_union_and_rank_select_test;
  import isu_pkg::*;

  localparam int MAXN = DEF_MAX_INTERVALS;
  localparam logic [TOTAL_W-1:0] TOT_SAT = {TOTAL_W{1'b1}};

  typedef struct packed {
    logic [1:0]         status;
    logic [FIELD_W-1:0] lo;
    logic [FIELD_W-1:0] hi;
    logic [TOTAL_W-1:0] total;
    logic               fz;
    logic               empty;
    logic               lst;
  } piece_t;

  class interval_scoreboard;
    logic [FIELD_W-1:0] lows[MAXN];
    logic [FIELD_W-1:0] highs[MAXN];
    int                 count;
    bit                 merged;
    logic [TOTAL_W-1:0] covered;
    piece_t             pending[$];
    int                 errors;

    function new();
      count = 0;
      merged = 1;
      covered = '0;
      errors = 0;
    endfunction

    function void push(logic [1:0] st, logic [FIELD_W-1:0] lo, logic [FIELD_W-1:0] hi,
                       logic [TOTAL_W-1:0] tot, logic fz, logic em, logic ls);
      piece_t p;
      p.status = st;
      p.lo = lo;
      p.hi = hi;
      p.total = tot;
      p.fz = fz;
      p.empty = em;
      p.lst = ls;
      pending = {pending, p};
    endfunction

    function logic starts_at_zero();
      return (count == 0) || (count == 1 && lows[0] == '0);
    endfunction

    function void merge_store();
      logic [FIELD_W-1:0] sl[MAXN];
      logic [FIELD_W-1:0] sh[MAXN];
      logic [FIELD_W-1:0] tl;
      logic [FIELD_W-1:0] th;
      logic [TOTAL_W:0]   acc;
      int m;
      int j;
      for (int i = 0; i < count; i++) begin
        sl[i] = lows[i];
        sh[i] = highs[i];
      end
      for (int i = 1; i < count; i++) begin
        tl = sl[i];
        th = sh[i];
        j = i;
        while (j > 0 && (sl[j-1] > tl || (sl[j-1] == tl && sh[j-1] > th))) begin
          sl[j] = sl[j-1];
          sh[j] = sh[j-1];
          j--;
        end
        sl[j] = tl;
        sh[j] = th;
      end
      m = 0;
      for (int i = 0; i < count; i++) begin
        if (sh[i] > sl[i]) begin
          if (m == 0 || highs[m-1] < sl[i]) begin
            lows[m] = sl[i];
            highs[m] = sh[i];
            m++;
          end else if (sh[i] > highs[m-1]) begin
            highs[m-1] = sh[i];
          end
        end
      end
      acc = '0;
      for (int i = 0; i < m; i++) begin
        acc += highs[i] - lows[i];
        if (acc > TOT_SAT) acc = TOT_SAT;
      end
      count = m;
      covered = acc[TOTAL_W-1:0];
      merged = 1;
    endfunction

    function void note_request(logic [1:0] cmd, logic [FIELD_W-1:0] lo, logic [FIELD_W-1:0] hi,
                               logic [TOTAL_W-1:0] r0, logic [TOTAL_W-1:0] r1);
      logic [TOTAL_W-1:0] cur;
      logic [TOTAL_W-1:0] len;
      logic [TOTAL_W-1:0] st;
      logic [TOTAL_W-1:0] en;
      logic               fz;
      int k;
      case (cmd)
        CMD_ADD: begin
          if (hi < lo) begin
            push(ST_BAD_BNDS, 0, 0, 0, 0, 1, 1);
          end else if (count >= MAXN) begin
            push(ST_FULL, 0, 0, 0, 0, 1, 1);
          end else begin
            lows[count] = lo;
            highs[count] = hi;
            count++;
            merged = 0;
            push(ST_OK, 0, 0, 0, 0, 1, 1);
          end
        end
        CMD_NORMALIZE: begin
          merge_store();
          fz = starts_at_zero();
          if (count == 0) push(ST_OK, 0, 0, covered, fz, 1, 1);
          for (int i = 0; i < count; i++)
            push(ST_OK, lows[i], highs[i], covered, fz, 0, i == count - 1);
        end
        CMD_QUERY: begin
          if (!merged) begin
            push(ST_NOT_NORM, 0, 0, 0, 0, 1, 1);
          end else begin
            fz = starts_at_zero();
            cur = '0;
            k = 0;
            for (int i = 0; i < count; i++) begin
              len = highs[i] - lows[i];
              st = (r0 > cur) ? r0 - cur : '0;
              if (r1 > cur && st < len) begin
                en = (r1 >= cur + len) ? len : r1 - cur;
                if (en > st) begin
                  push(ST_OK, lows[i] + st[FIELD_W-1:0], lows[i] + en[FIELD_W-1:0],
                       covered, fz, 0, 0);
                  k++;
                end
              end
              cur += len;
            end
            if (k == 0) push(ST_OK, 0, 0, covered, fz, 1, 1);
            else pending[$].lst = 1;
          end
        end
        default: begin
          count = 0;
          merged = 1;
          covered = '0;
          push(ST_OK, 0, 0, 0, 1, 1, 1);
        end
      endcase
    endfunction

    function void check_result(piece_t got);
      piece_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Unexpected result: status %0d lo %h hi %h",
                                   got.status, got.lo, got.hi);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display("Mismatch: exp st%0d %h %h tot %h fz%0d e%0d l%0d, got st%0d %h %h tot %h fz%0d e%0d l%0d",
                   want.status, want.lo, want.hi, want.total, want.fz, want.empty, want.lst,
                   got.status, got.lo, got.hi, got.total, got.fz, got.empty, got.lst);
      end
    endfunction
  endclass

  logic               clk = 0;
  logic               rst = 1;
  logic               start = 0;
  logic               busy;
  logic [1:0]         command = CMD_ADD;
  logic [FIELD_W-1:0] lower = '0;
  logic [FIELD_W-1:0] upper = '0;
  logic [TOTAL_W-1:0] rank_start = '0;
  logic [TOTAL_W-1:0] rank_end = '0;
  logic               valid;
  logic [1:0]         status;
  logic [FIELD_W-1:0] lower_res;
  logic [FIELD_W-1:0] upper_res;
  logic [TOTAL_W-1:0] total_size;
  logic               from_zero;
  logic               is_empty;
  logic               last;

  interval_scoreboard sb = new();
  int unsigned cycles = 0;

  always #6 clk = ~clk;

  interval_set_union_and_rank_select dut (.*);

  always @(posedge clk) begin
    piece_t got;
    cycles <= cycles + 1;
    if (!rst && valid) begin
      got.status = status;
      got.lo = lower_res;
      got.hi = upper_res;
      got.total = total_size;
      got.fz = from_zero;
      got.empty = is_empty;
      got.lst = last;
      sb.check_result(got);
    end
    if (cycles > 400000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Start stays high when the next request follows with no gap.
  task automatic idle_gap();
    int n;
    n = $urandom_range(0, 9) < 6 ? 0 : ($urandom_range(0, 9) < 8 ? $urandom_range(1, 3)
                                                                   : $urandom_range(10, 40));
    if (n > 0) begin
      start <= 0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send(logic [1:0] cmd, logic [FIELD_W-1:0] lo, logic [FIELD_W-1:0] hi,
                      logic [TOTAL_W-1:0] r0, logic [TOTAL_W-1:0] r1);
    start <= 1;
    command <= cmd;
    lower <= lo;
    upper <= hi;
    rank_start <= r0;
    rank_end <= r1;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_request(cmd, lo, hi, r0, r1);
    idle_gap();
  endtask

  function automatic logic [TOTAL_W-1:0] rand_rank();
    case ($urandom_range(0, 3))
      0: return TOTAL_W'({$urandom, $urandom});
      1: return TOT_SAT;
      default: return TOTAL_W'($urandom_range(0, 300));
    endcase
  endfunction

  task automatic add_random();
    logic [FIELD_W-1:0] a;
    logic [FIELD_W-1:0] b;
    case ($urandom_range(0, 3))
      0: begin
        a = $urandom;
        b = $urandom;
      end
      1: begin
        a = $urandom | 32'hffff_ff00;
        b = a + $urandom_range(0, 255);
        if (b < a) b = 32'hffff_ffff;
      end
      default: begin
        a = $urandom_range(0, 200);
        b = a + $urandom_range(0, 40) - ($urandom_range(0, 9) == 0 ? 5 : 0);
      end
    endcase
    send(CMD_ADD, a, b, rand_rank(), rand_rank());
  endtask

  initial begin
    int sent;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    send(CMD_QUERY, 0, 0, 0, 10);
    send(CMD_NORMALIZE, 0, 0, 0, 0);
    send(CMD_ADD, 10, 5, 0, 0);
    send(CMD_ADD, 0, 10, 0, 0);
    send(CMD_QUERY, 0, 0, 0, 5);
    send(CMD_ADD, 10, 20, 0, 0);
    send(CMD_ADD, 7, 7, 0, 0);
    send(CMD_ADD, 32'hffff_fff0, 32'hffff_ffff, 0, 0);
    send(CMD_NORMALIZE, 0, 0, 0, 0);
    send(CMD_QUERY, 0, 0, 5, 25);
    send(CMD_QUERY, 0, 0, 9, 3);
    send(CMD_QUERY, 0, 0, 0, TOT_SAT);
    send(CMD_QUERY, 0, 0, TOT_SAT, TOT_SAT);
    for (int i = 0; i < 17; i++) send(CMD_ADD, 3 * i, 3 * i + 2, 0, 0);
    send(CMD_NORMALIZE, 0, 0, 0, 0);
    send(CMD_CLEAR, 32'hffff_ffff, 32'hffff_ffff, TOT_SAT, TOT_SAT);
    send(CMD_ADD, 0, 32'hffff_ffff, 0, 0);
    send(CMD_NORMALIZE, 0, 0, 0, 0);

    sent = 0;
    while (sent < 320) begin
      int n;
      if ($urandom_range(0, 9) < 8) begin
        n = $urandom_range(0, 18);
        for (int i = 0; i < n; i++) add_random();
        if ($urandom_range(0, 9) == 0) send(CMD_QUERY, 0, 0, rand_rank(), rand_rank());
        send(CMD_NORMALIZE, 0, 0, 0, 0);
        repeat ($urandom_range(1, 4)) send(CMD_QUERY, 0, 0, rand_rank(), rand_rank());
        sent += n + 3;
      end else begin
        send(2'($urandom_range(0, 3)), $urandom, $urandom, rand_rank(), rand_rank());
        sent++;
      end
      if ($urandom_range(0, 7) == 0) begin
        send(CMD_CLEAR, $urandom, $urandom, rand_rank(), rand_rank());
        sent++;
      end
    end
    start <= 0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
